// ----- hdl/ctps_pkg.sv -----
`default_nettype none

package ctps_pkg;

    typedef enum logic [1:0] {
        OP_PAD_POLL   = 2'd0,
        OP_REAL_CELL  = 2'd1,
        OP_BURST_POLL = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NOW_W      = 48;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned CNT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COVER_SPACING = 3'd5;

    localparam logic [MS_W-1:0]  RST_PAD_INTERVAL  = 16'd50;
    localparam logic [MS_W-1:0]  RST_GAP_THRESHOLD = 16'd200;
    localparam logic [CNT_W-1:0] RST_BURST_LEN     = 8'd5;
    localparam logic [MS_W-1:0]  RST_COVER_SPACING = 16'd30;

    typedef struct packed {
        logic             constant_mode_on;
        logic             adaptive_mode_on;
        logic [MS_W-1:0]  pad_interval_ms;
        logic [MS_W-1:0]  gap_threshold_ms;
        logic [CNT_W-1:0] cover_burst_len;
        logic [MS_W-1:0]  cover_spacing_ms;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/ctps_cfg.sv -----
`default_nettype none

module ctps_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                wr_en,
    input  wire logic [ctps_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire logic [ctps_pkg::CFG_DATA_W-1:0]     wr_data,
    output ctps_pkg::cfg_t                           cfg
);

    ctps_pkg::cfg_t cfg_reg;
    ctps_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                ctps_pkg::REG_CONSTANT_MODE: cfg_next.constant_mode_on = wr_data[0];
                ctps_pkg::REG_ADAPTIVE_MODE: cfg_next.adaptive_mode_on = wr_data[0];
                ctps_pkg::REG_PAD_INTERVAL:  cfg_next.pad_interval_ms  = wr_data;
                ctps_pkg::REG_GAP_THRESHOLD: cfg_next.gap_threshold_ms = wr_data;
                ctps_pkg::REG_BURST_LEN:
                    cfg_next.cover_burst_len = wr_data[ctps_pkg::CNT_W-1:0];
                ctps_pkg::REG_COVER_SPACING: cfg_next.cover_spacing_ms = wr_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.constant_mode_on <= 1'b0;
            cfg_reg.adaptive_mode_on <= 1'b0;
            cfg_reg.pad_interval_ms  <= ctps_pkg::RST_PAD_INTERVAL;
            cfg_reg.gap_threshold_ms <= ctps_pkg::RST_GAP_THRESHOLD;
            cfg_reg.cover_burst_len  <= ctps_pkg::RST_BURST_LEN;
            cfg_reg.cover_spacing_ms <= ctps_pkg::RST_COVER_SPACING;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/ctps_decide.sv -----
`default_nettype none

module ctps_decide #(
    parameter int unsigned TIME_BITS = 48
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ctps_pkg::cfg_t                    cfg,
    input  wire logic                              fire,
    input  wire logic [1:0]                        opcode,
    input  wire logic [TIME_BITS-1:0]              now,
    output logic                                   send_pad,
    output logic [ctps_pkg::CNT_W-1:0]             cover_armed
);

    localparam int unsigned MS_W = ctps_pkg::MS_W;

    logic [TIME_BITS-1:0]        last_pad_reg,  last_pad_next;
    logic [TIME_BITS-1:0]        last_real_reg, last_real_next;
    logic                        burst_on_reg,  burst_on_next;
    logic [ctps_pkg::CNT_W-1:0]  cover_left_reg, cover_left_next;

    logic [TIME_BITS-1:0] pad_diff;
    logic [TIME_BITS-1:0] real_diff;
    logic                 pad_set, pad_fwd, pad_diff_hi;
    logic                 real_set, real_fwd, real_diff_hi;
    logic                 pad_due, cover_hold, gap_seen;

    assign pad_set      = last_pad_reg != '0;
    assign pad_fwd      = now >= last_pad_reg;
    assign pad_diff     = now - last_pad_reg;
    assign pad_diff_hi  = |pad_diff[TIME_BITS-1:MS_W];
    assign real_set     = last_real_reg != '0;
    assign real_fwd     = now >= last_real_reg;
    assign real_diff    = now - last_real_reg;
    assign real_diff_hi = |real_diff[TIME_BITS-1:MS_W];

    assign pad_due    = pad_fwd && (pad_diff_hi || pad_diff[MS_W-1:0] >= cfg.pad_interval_ms);
    assign cover_hold = pad_set && pad_fwd && !pad_diff_hi
                        && pad_diff[MS_W-1:0] < cfg.cover_spacing_ms;
    assign gap_seen   = real_set && real_fwd
                        && (real_diff_hi || real_diff[MS_W-1:0] > cfg.gap_threshold_ms);

    always_comb begin
        last_pad_next   = last_pad_reg;
        last_real_next  = last_real_reg;
        burst_on_next   = burst_on_reg;
        cover_left_next = cover_left_reg;
        send_pad        = 1'b0;
        cover_armed     = '0;
        unique case (ctps_pkg::opcode_t'(opcode))
            ctps_pkg::OP_PAD_POLL: begin
                if (cfg.constant_mode_on) begin
                    if (!pad_set) begin
                        last_pad_next = now;
                    end else if (pad_due) begin
                        last_pad_next = now;
                        send_pad      = 1'b1;
                    end
                end
            end
            ctps_pkg::OP_REAL_CELL: begin
                if (cfg.adaptive_mode_on) begin
                    if (gap_seen) begin
                        burst_on_next   = 1'b1;
                        cover_left_next = cfg.cover_burst_len;
                        cover_armed     = cfg.cover_burst_len;
                    end
                    last_pad_next = now;
                end
                last_real_next = now;
            end
            ctps_pkg::OP_BURST_POLL: begin
                if (!burst_on_reg || cover_left_reg == '0) begin
                    burst_on_next = 1'b0;
                end else if (!cover_hold) begin
                    cover_left_next = cover_left_reg - 1'b1;
                    last_pad_next   = now;
                    burst_on_next   = cover_left_reg != 8'd1;
                    send_pad        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pad_reg   <= '0;
            last_real_reg  <= '0;
            burst_on_reg   <= 1'b0;
            cover_left_reg <= '0;
        end else if (fire) begin
            last_pad_reg   <= last_pad_next;
            last_real_reg  <= last_real_next;
            burst_on_reg   <= burst_on_next;
            cover_left_reg <= cover_left_next;
        end
    end

    // an idle burst never holds leftover cover cells
    a_idle_burst_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !burst_on_reg |-> cover_left_reg == '0)
        else $error("cover cells left with burst off");

    a_real_no_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        opcode == ctps_pkg::OP_REAL_CELL |-> !send_pad)
        else $error("real cell produced a pad");

    a_armed_only_real: assert property (@(posedge aclk) disable iff (!aresetn)
        cover_armed != '0 |-> opcode == ctps_pkg::OP_REAL_CELL)
        else $error("cover count on a non-real event");

    a_pad_resyncs: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && send_pad |=> last_pad_reg == $past(now))
        else $error("pad time not updated after a pad");

endmodule

`default_nettype wire

// ----- hdl/cover_traffic_padding_scheduler.sv -----
`default_nettype none

// Cover-traffic padding scheduler. Takes one timestamped event word per cycle
// (pad poll, real cell, burst poll) unless result backpressure stalls it, and
// returns one result word per event: send_pad and the number of cover cells
// armed. Each word passes an input register, then the decision logic and state
// update feeding the result register; sustained rate is one word per cycle
// while the result side keeps up. Result backpressure stalls the input side
// only once both registers are full. Configuration writes are accepted every
// cycle and must only be issued while no word is in flight.
module cover_traffic_padding_scheduler #(
    parameter int unsigned TIME_BITS = 48
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_opcode,
    input  wire logic [ctps_pkg::NOW_W-1:0]        s_now_ms,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_send_pad,
    output logic [ctps_pkg::CNT_W-1:0]             m_cover_armed,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ctps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ctps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ctps_pkg::cfg_t cfg;

    logic                        in_valid_reg;
    logic [1:0]                  in_op_reg;
    logic [TIME_BITS-1:0]        in_now_reg;
    logic                        out_valid_reg;
    logic                        out_pad_reg;
    logic [ctps_pkg::CNT_W-1:0]  out_armed_reg;

    logic                        advance;
    logic                        fire;
    logic                        dec_pad;
    logic [ctps_pkg::CNT_W-1:0]  dec_armed;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;

    ctps_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ctps_decide #(
        .TIME_BITS (TIME_BITS)
    ) u_decide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .fire        (fire),
        .opcode      (in_op_reg),
        .now         (in_now_reg),
        .send_pad    (dec_pad),
        .cover_armed (dec_armed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg  <= s_opcode;
            in_now_reg <= TIME_BITS'(s_now_ms);
        end
        if (fire) begin
            out_pad_reg   <= dec_pad;
            out_armed_reg <= dec_armed;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_send_pad    = out_pad_reg;
    assign m_cover_armed = out_armed_reg;

endmodule

`default_nettype wire
